FILE: design/fpd_pkg.sv
package fpd_pkg;

   localparam int WORD_BITS = 64;
   localparam int FRAC_BITS = 32;
   localparam int STEPS     = WORD_BITS + FRAC_BITS;
   localparam int CNT_W     = $clog2(STEPS);

   localparam logic [WORD_BITS-1:0] MAX_MAG = {1'b0, {(WORD_BITS-1){1'b1}}};

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic start;
      logic pop;
   } core_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_sts_type;

endpackage

FILE: design/fpd_core.sv
module fpd_core
   import fpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  core_ctl_type ctl,
   input  word_type     num_mag,
   input  word_type     den_mag,
   output core_sts_type sts,
   output word_type     quo,
   output logic         sat
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   word_type         num_ff, num_in;
   word_type         den_ff, den_in;
   word_type         rem_ff, rem_in;
   word_type         quo_ff, quo_in;
   logic             sat_ff, sat_in;

   logic             bit_in;
   logic [WORD_BITS:0] shifted;
   logic [WORD_BITS:0] trial;
   logic             ge;

   assign bit_in  = num_ff[WORD_BITS-1];
   assign shifted = {rem_ff, bit_in};
   assign trial   = shifted - {1'b0, den_ff};
   assign ge      = ~trial[WORD_BITS];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      sat_in   = sat_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               num_in   = num_mag;
               den_in   = den_mag;
               rem_in   = '0;
               quo_in   = '0;
               sat_in   = 1'b0;
               cnt_in   = '0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            num_in = {num_ff[WORD_BITS-2:0], 1'b0};
            rem_in = ge ? trial[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
            quo_in = {quo_ff[WORD_BITS-2:0], ge};
            sat_in = sat_ff | quo_ff[WORD_BITS-2];
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (ctl.pop) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign sts.busy = (state_ff != S_IDLE);
   assign sts.done = (state_ff == S_DONE);
   assign quo      = quo_ff;
   assign sat      = sat_ff;

`ifndef SYNTHESIS
   a_start_clears_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && ctl.start) |=> (cnt_ff == '0 && state_ff == S_RUN))
      else $error("count not cleared on start");
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !ctl.pop) |=> (state_ff == S_DONE && $stable(quo_ff)))
      else $error("finished result lost before pop");
   a_divisor_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |=> $stable(den_ff))
      else $error("divisor changed mid-division");
   a_sat_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && sat_ff) |=> sat_ff)
      else $error("saturation flag dropped");
`endif

endmodule

FILE: design/fixed_point_divide_q32_32.sv
// Signed Q32.32 divider, one quotient per item.
// Request channel: req_dividend and req_divisor, 64-bit two's complement,
// taken on a rising edge with req_valid high and req_stall low.
// Response channel: rsp_quotient, 64-bit two's complement, one beat per
// request, taken on a rising edge with rsp_valid high and rsp_stall low.
// A zero operand gives zero; a quotient magnitude at or above 2^63-1
// saturates to 2^63-1 and carries the sign of the operands.
// Timing: the restoring shift-subtract loop produces one quotient bit per
// cycle over 96 steps; the result then moves into the output register when
// that register is free, and the next request is taken after the hand-off.
// One request at a time is in the loop; the output register holds a
// finished result while the loop starts on the next request.
// When rsp_stall is high the response holds steady; a second finished
// result waits inside the loop and req_stall stays high until it moves on.
// Reset is synchronous and active high; it drops any request in flight
// and any pending response, and req_stall is high while reset is applied.
module fixed_point_divide_q32_32
   import fpd_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [WORD_BITS-1:0] req_dividend,
   input  logic signed [WORD_BITS-1:0] req_divisor,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [WORD_BITS-1:0] rsp_quotient
);

   core_ctl_type ctl;
   core_sts_type sts;
   word_type     num_mag, den_mag;
   word_type     core_quo;
   logic         core_sat;

   logic         neg_ff, neg_in;
   logic         zero_ff, zero_in;
   logic         rsp_valid_ff, rsp_valid_in;
   word_type     rsp_quo_ff, rsp_quo_in;

   logic         accept;
   logic         out_free;
   word_type     mag;

   assign req_stall = sts.busy | reset;
   assign accept    = req_valid & ~req_stall;

   assign num_mag = req_dividend[WORD_BITS-1] ? (word_type'(0) - word_type'(req_dividend))
                                              : word_type'(req_dividend);
   assign den_mag = req_divisor[WORD_BITS-1] ? (word_type'(0) - word_type'(req_divisor))
                                             : word_type'(req_divisor);

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign ctl.start = accept;
   assign ctl.pop   = sts.done & out_free;

   fpd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .num_mag (num_mag),
      .den_mag (den_mag),
      .sts     (sts),
      .quo     (core_quo),
      .sat     (core_sat)
   );

   always_comb begin
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (accept) begin
         neg_in  = req_dividend[WORD_BITS-1] ^ req_divisor[WORD_BITS-1];
         zero_in = (req_dividend == '0) | (req_divisor == '0);
      end
   end

   always_comb begin
      if (zero_ff) begin
         mag = '0;
      end else if (core_sat || core_quo == MAX_MAG) begin
         mag = MAX_MAG;
      end else begin
         mag = core_quo;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_quo_in   = rsp_quo_ff;
      if (ctl.pop) begin
         rsp_valid_in = 1'b1;
         rsp_quo_in   = neg_ff ? (word_type'(0) - mag) : mag;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff     <= neg_in;
      zero_ff    <= zero_in;
      rsp_quo_ff <= rsp_quo_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_quotient = rsp_quo_ff;

endmodule
